/* sv/firlt_pkg.sv */
package firlt_pkg;

    localparam int HALF_TAPS    = 15;
    localparam int TAPS         = 2 * HALF_TAPS + 1;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int FRAC_BITS    = COEF_WIDTH - 2;
    localparam int TAP_FIELD_W  = 5;
    localparam int TAP_IDX_W    = $clog2(TAPS);
    localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
    // one guard bit on top of the growth over all taps, so the rounding add cannot wrap
    localparam int ACC_W        = PROD_W + $clog2(TAPS) + 1;
    localparam int S_TDATA_W    = ((TAP_FIELD_W + SAMPLE_WIDTH + COEF_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_COEF   = 1'b1
    } t_kind;

    typedef struct packed {
        logic                 shift;
        logic                 wr_coef;
        logic                 mac;
        logic [TAP_IDX_W-1:0] idx;
        logic                 load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_status;

endpackage

/* sv/firlt_ctrl.sv */
module firlt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_kind,
    input  firlt_pkg::t_dp_status i_status,
    output logic                  o_ready,
    output firlt_pkg::t_dp_cmd    o_cmd
);

    firlt_pkg::t_state                  r_state, n_state;
    logic [firlt_pkg::TAP_IDX_W-1:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= firlt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_ready        = 1'b0;
        o_cmd          = '0;
        o_cmd.idx      = r_cnt;
        unique case (r_state)
            firlt_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_kind == firlt_pkg::KIND_COEF) begin
                        o_cmd.wr_coef = 1'b1;
                    end else begin
                        o_cmd.shift = 1'b1;
                        n_cnt       = '0;
                        n_state     = firlt_pkg::ST_MAC;
                    end
                end
            end
            firlt_pkg::ST_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_cnt == firlt_pkg::TAP_IDX_W'(firlt_pkg::TAPS - 1)) begin
                    n_state = firlt_pkg::ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            firlt_pkg::ST_FLUSH: begin
                // last product lands in the accumulator
                n_state = firlt_pkg::ST_DONE;
            end
            firlt_pkg::ST_DONE: begin
                if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = firlt_pkg::ST_IDLE;
                end
            end
            default: n_state = firlt_pkg::ST_IDLE;
        endcase
    end

endmodule

/* sv/firlt_dp.sv */
module firlt_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  firlt_pkg::t_dp_cmd                     i_cmd,
    input  logic [firlt_pkg::TAP_FIELD_W-1:0]      i_tap_index,
    input  logic signed [firlt_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [firlt_pkg::COEF_WIDTH-1:0]   i_coefficient,
    input  logic                                   i_out_ready,
    output firlt_pkg::t_dp_status                  o_status,
    output logic                                   o_out_valid,
    output logic signed [firlt_pkg::SAMPLE_WIDTH-1:0] o_filtered,
    output logic                                   o_saturated
);

    logic signed [firlt_pkg::SAMPLE_WIDTH-1:0] r_dly  [firlt_pkg::TAPS];
    logic signed [firlt_pkg::COEF_WIDTH-1:0]   r_coef [firlt_pkg::TAPS];
    logic signed [firlt_pkg::PROD_W-1:0]       r_prod;
    logic                                      r_prod_vld;
    logic signed [firlt_pkg::ACC_W-1:0]        r_acc;
    logic                                      r_out_valid;
    logic signed [firlt_pkg::SAMPLE_WIDTH-1:0] r_out_data;
    logic                                      r_out_sat;

    logic signed [firlt_pkg::ACC_W-1:0]        w_rnd;
    logic signed [firlt_pkg::ACC_W-1:0]        w_shr;
    logic signed [firlt_pkg::SAMPLE_WIDTH-1:0] w_y;
    logic                                      w_sat;

    // delay line and coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < firlt_pkg::TAPS; k++) begin
                r_dly[k]  <= '0;
                r_coef[k] <= '0;
            end
        end else begin
            if (i_cmd.shift) begin
                for (int k = firlt_pkg::TAPS - 1; k > 0; k--) begin
                    r_dly[k] <= r_dly[k-1];
                end
                r_dly[0] <= i_sample;
            end
            // index 31 is past the last tap and is dropped
            if (i_cmd.wr_coef && (32'(i_tap_index) < 32'(firlt_pkg::TAPS))) begin
                r_coef[firlt_pkg::TAP_IDX_W'(i_tap_index)] <= i_coefficient;
            end
        end
    end

    // one multiply per cycle, registered, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mac;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_dly[i_cmd.idx] * r_coef[i_cmd.idx];
        if (i_cmd.shift) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + firlt_pkg::ACC_W'(r_prod);
        end
    end

    // round half up, then clip to sample range
    always_comb begin
        w_rnd = r_acc + firlt_pkg::ROUND_HALF;
        w_shr = w_rnd >>> firlt_pkg::FRAC_BITS;
        if (w_shr > firlt_pkg::SAT_MAX) begin
            w_y   = firlt_pkg::OUT_MAX;
            w_sat = 1'b1;
        end else if (w_shr < firlt_pkg::SAT_MIN) begin
            w_y   = firlt_pkg::OUT_MIN;
            w_sat = 1'b1;
        end else begin
            w_y   = w_shr[firlt_pkg::SAMPLE_WIDTH-1:0];
            w_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= w_y;
            r_out_sat  <= w_sat;
        end
    end

    assign o_status.out_full = r_out_valid & ~i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_filtered        = r_out_data;
    assign o_saturated       = r_out_sat;

endmodule

/* sv/fir_filter_loadable_taps.sv */
// Direct-form FIR filter, 31 taps, Q2.14 coefficients loaded over the input stream.
// A beat with tuser = 1 writes one coefficient (tap index 0 weights the newest
// sample; index 31 is ignored) and is taken without stalling and with no output. A beat
// with tuser = 0 shifts a sample in and yields one output beat: from one accepted
// sample beat to the next the block passes through the accepting cycle, one multiply
// per tap through the single multiplier, a flush step and a round/saturate step;
// the last of these stretches for as long as the previous result still waits
// unaccepted at the output.
// The output register lets the next beat be accepted while a result waits.
// Output is rounded half up and clipped to 16 bits; tuser flags clipping.
// Coefficients and delay line clear to zero at reset.
module fir_filter_loadable_taps (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tap_index [4:0], sample [20:5], coefficient [36:21], zero pad to 40
    input  logic [firlt_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // kind [0]
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // filtered [15:0]
    output logic [firlt_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // saturated [0]
    output logic                               o_m_tuser
);

    localparam int SMP_LO = firlt_pkg::TAP_FIELD_W;
    localparam int CF_LO  = SMP_LO + firlt_pkg::SAMPLE_WIDTH;

    firlt_pkg::t_dp_cmd                        w_cmd;
    firlt_pkg::t_dp_status                     w_status;
    logic signed [firlt_pkg::SAMPLE_WIDTH-1:0] w_filtered;

    firlt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_kind   (i_s_tuser),
        .i_status (w_status),
        .o_ready  (o_s_tready),
        .o_cmd    (w_cmd)
    );

    firlt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_tap_index   (i_s_tdata[firlt_pkg::TAP_FIELD_W-1:0]),
        .i_sample      (i_s_tdata[CF_LO-1:SMP_LO]),
        .i_coefficient (i_s_tdata[CF_LO+firlt_pkg::COEF_WIDTH-1:CF_LO]),
        .i_out_ready   (i_m_tready),
        .o_status      (w_status),
        .o_out_valid   (o_m_tvalid),
        .o_filtered    (w_filtered),
        .o_saturated   (o_m_tuser)
    );

    assign o_m_tdata = firlt_pkg::M_TDATA_W'($unsigned(w_filtered));

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == firlt_pkg::KIND_SAMPLE)) |=> !o_s_tready)
        else $error("sample beat did not start a filter run");

    a_coef_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == firlt_pkg::KIND_COEF)) |=> o_s_tready)
        else $error("coefficient write held the input");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_cmd.load_out))
        else $error("output valid without a result load");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (w_filtered == firlt_pkg::OUT_MAX || w_filtered == firlt_pkg::OUT_MIN))
        else $error("saturation flag on an unclipped value");

endmodule
